// File: rtl/core/kvlp_pkg.sv
// Package for the key/value line parser: constants, register codes and shared types.
package kvlp_pkg;

   localparam int unsigned MAX_NAME = 16;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_EQUAL = 8'h3D;

   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WILDCARD_MODE   = 3'd0,
      CSR_NAME_CHARS_LOW  = 3'd1,
      CSR_NAME_CHARS_HIGH = 3'd2,
      CSR_NAME_LENGTH     = 3'd3,
      CSR_NAME_CAPACITY   = 3'd4,
      CSR_VALUE_CAPACITY  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_NAME  = 2'd1,
      KIND_VALUE = 2'd2
   } char_kind_type;

   typedef enum logic [6:0] {
      PH_SKIP     = 7'b0000001,
      PH_NAME     = 7'b0000010,
      PH_EQ       = 7'b0000100,
      PH_POSTEQ   = 7'b0001000,
      PH_QUOTED   = 7'b0010000,
      PH_UNQUOTED = 7'b0100000,
      PH_DONE     = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic         wildcard_mode;
      logic [127:0] name_chars;
      logic [4:0]   name_length;
      logic [4:0]   name_capacity;
      logic [7:0]   value_capacity;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [4:0] name_position;
      logic [7:0] value_count;
      logic       line_failed;
   } state_type;

   typedef struct packed {
      char_kind_type char_kind;
      logic [7:0]    char_byte;
      logic [7:0]    char_index;
      logic          line_done;
      logic [7:0]    value_length;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_SKIP,
      name_position: 5'd0,
      value_count:   8'd0,
      line_failed:   1'b0
   };

endpackage

// File: rtl/core/kvlp_csr.sv
// Configuration register file of the key/value line parser.
module kvlp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kvlp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_data,
   output kvlp_pkg::cfg_type                  cfg
);
   import kvlp_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wildcard_mode  <= 1'b0;
         cfg_ff.name_chars     <= '0;
         cfg_ff.name_length    <= 5'd0;
         cfg_ff.name_capacity  <= 5'd16;
         cfg_ff.value_capacity <= 8'd255;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WILDCARD_MODE:   cfg_ff.wildcard_mode         <= csr_data[0];
            CSR_NAME_CHARS_LOW:  cfg_ff.name_chars[63:0]      <= csr_data;
            CSR_NAME_CHARS_HIGH: cfg_ff.name_chars[127:64]    <= csr_data;
            CSR_NAME_LENGTH:     cfg_ff.name_length           <= csr_data[4:0];
            CSR_NAME_CAPACITY:   cfg_ff.name_capacity         <= csr_data[4:0];
            CSR_VALUE_CAPACITY:  cfg_ff.value_capacity        <= csr_data[7:0];
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/core/kvlp_step.sv
// Per-character parse step: next line state and result item for one character.
module kvlp_step (
   input  kvlp_pkg::state_type  state_cur,
   input  kvlp_pkg::cfg_type    cfg,
   input  logic [7:0]           ch,
   input  logic                 end_of_line,
   output kvlp_pkg::state_type  state_nxt,
   output kvlp_pkg::result_type result
);
   import kvlp_pkg::*;

   localparam logic [4:0] MaxName = 5'(MAX_NAME);

   logic       blank;
   logic       alnum;
   logic       last;
   logic [4:0] cap;
   logic [4:0] len;
   logic [7:0] match_byte;

   assign blank = ch inside {CH_TAB, CH_SPACE};
   assign alnum = ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
   assign last  = end_of_line || (ch == CH_NUL);
   assign cap   = (cfg.name_capacity > MaxName) ? MaxName : cfg.name_capacity;
   assign len   = (cfg.name_length > MaxName) ? MaxName : cfg.name_length;
   assign match_byte = cfg.name_chars[{state_cur.name_position[3:0], 3'b000} +: 8];

   always_comb begin
      state_type  st;
      logic       run_name;
      logic       run_eq;
      logic       run_value;
      logic [4:0] npos_inc;
      logic [7:0] vcnt_inc;

      st        = state_cur;
      run_name  = 1'b0;
      run_eq    = 1'b0;
      run_value = 1'b0;
      npos_inc  = state_cur.name_position + 5'd1;
      vcnt_inc  = state_cur.value_count + 8'd1;
      result    = '{char_kind: KIND_NONE, char_byte: 8'd0, char_index: 8'd0,
                    line_done: last, value_length: 8'd0};

      // NUL ends the line without being parsed
      if (ch != CH_NUL) begin
         case (state_cur.phase)
            PH_SKIP:     run_name = !blank;
            PH_NAME:     run_name = 1'b1;
            PH_EQ:       run_eq   = 1'b1;
            PH_POSTEQ: begin
               if (blank) begin
                  st.phase = PH_POSTEQ;
               end else if (ch == CH_QUOTE) begin
                  st.phase = (cfg.value_capacity == 8'd0) ? PH_DONE : PH_QUOTED;
               end else begin
                  run_value = 1'b1;
               end
            end
            PH_QUOTED: begin
               if (ch == CH_QUOTE || ch == CH_LF || ch == CH_CR) begin
                  st.phase = PH_DONE;
               end else begin
                  result.char_kind  = KIND_VALUE;
                  result.char_byte  = ch;
                  result.char_index = state_cur.value_count;
                  st.value_count    = vcnt_inc;
                  if (vcnt_inc >= cfg.value_capacity) st.phase = PH_DONE;
               end
            end
            PH_UNQUOTED: run_value = 1'b1;
            default: ;
         endcase
      end

      if (run_name) begin
         if (cfg.wildcard_mode) begin
            if (state_cur.name_position >= cap || !alnum) begin
               if (state_cur.name_position == 5'd0) begin
                  st.line_failed = 1'b1;
                  st.phase       = PH_DONE;
               end else begin
                  run_eq = 1'b1;
               end
            end else begin
               result.char_kind  = KIND_NAME;
               result.char_byte  = ch;
               result.char_index = {3'b000, state_cur.name_position};
               st.name_position  = npos_inc;
               st.phase          = (npos_inc >= cap) ? PH_EQ : PH_NAME;
            end
         end else begin
            if (state_cur.name_position >= len) begin
               run_eq = 1'b1;
            end else if (ch != match_byte) begin
               st.line_failed = 1'b1;
               st.phase       = PH_DONE;
            end else begin
               st.name_position = npos_inc;
               st.phase         = (npos_inc >= len) ? PH_EQ : PH_NAME;
            end
         end
      end

      if (run_eq) begin
         if (blank) begin
            st.phase = PH_EQ;
         end else if (ch == CH_EQUAL) begin
            st.phase = PH_POSTEQ;
         end else begin
            st.line_failed = 1'b1;
            st.phase       = PH_DONE;
         end
      end

      if (run_value) begin
         if (state_cur.value_count >= cfg.value_capacity || !alnum) begin
            st.phase = PH_DONE;
         end else begin
            result.char_kind  = KIND_VALUE;
            result.char_byte  = ch;
            result.char_index = state_cur.value_count;
            st.value_count    = vcnt_inc;
            st.phase          = (vcnt_inc >= cfg.value_capacity) ? PH_DONE : PH_UNQUOTED;
         end
      end

      // report the length and start over at the end of the line
      if (last) begin
         if (!st.line_failed &&
             (st.phase == PH_QUOTED || st.phase == PH_UNQUOTED || st.phase == PH_DONE)) begin
            result.value_length = st.value_count;
         end
         st = STATE_RESET;
      end

      state_nxt = st;
   end

endmodule

// File: rtl/core/key_value_line_parser.sv
// Top level of the key/value line parser: stream ports, input and result registers.
// A character is taken into the input register, then moves to the result register,
// where its result shows on rsp_tvalid until the receiver takes it.
// Throughput: one character per cycle while rsp_tready stays high; the parse step between
// the input and result registers is a single pass of narrow compare-and-select logic.
// Reset (synchronous, active high): empties both stages, returns the line state
// to leading-blank skip and loads the configuration register reset values.
module key_value_line_parser (
   input  logic                              clock,
   input  logic                              reset,
   // input characters
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] ch
   input  logic                              req_tlast,   // end_of_line
   // results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // [7:0] char_byte,
                                                          // [15:8] char_index,
                                                          // [23:16] value_length
   output logic [1:0]                        rsp_tuser,   // [1:0] char_kind
   output logic                              rsp_tlast,   // line_done
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kvlp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [63:0]                       csr_data
);
   import kvlp_pkg::*;

   cfg_type    cfg;

   // input register stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;

   // line state carried from character to character
   state_type  state_ff, state_in;

   // result register stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, step_result;

   logic       out_free;
   logic       advance;

   kvlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kvlp_step u_step (
      .state_cur   (state_ff),
      .cfg         (cfg),
      .ch          (in_ch_ff),
      .end_of_line (in_last_ff),
      .state_nxt   (state_in),
      .result      (step_result)
   );

   // The result slot frees up when it is empty or its transaction completes now;
   // the input stage then hands its character over and can take a new one.
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || out_free;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // commit the line state only when the character moves to the result stage
         if (advance) state_ff <= state_in;
      end
   end

   // payload registers: load on an accepted transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) rsp_ff <= step_result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.value_length, rsp_ff.char_index, rsp_ff.char_byte};
   assign rsp_tuser  = rsp_ff.char_kind;
   assign rsp_tlast  = rsp_ff.line_done;

endmodule

// File: sim/key_value_line_parser_test.sv
// Self-checking testbench for the key/value line parser: random lines, stalls, CSR phases.
`timescale 1ns / 100ps

module key_value_line_parser_test;
   import kvlp_pkg::*;

   // Cycles without any transaction before the run is declared hung. The longest
   // legitimate quiet stretch is the receiver hold-off below plus a short drain.
   localparam int unsigned HANG_LIMIT   = 3000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned HOLD_TRIGGER = 200;
   localparam int unsigned IDLE_PERCENT = 21;
   localparam int unsigned PHASE_CHARS  = 55;

   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
   } char_item_type;

   // ------------------------------------------------------------------
   // Block ports; every input starts at a known value
   // ------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;   // [7:0] ch
   logic                   req_tlast  = 1'b0; // end_of_line
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;         // [7:0] char_byte, [15:8] char_index,
                                              // [23:16] value_length
   logic [1:0]             rsp_tuser;         // [1:0] char_kind
   logic                   rsp_tlast;         // line_done
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [63:0]            csr_data   = '0;

   key_value_line_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   char_item_type pending_chars[$];     // characters waiting to be offered
   result_type    expected_results[$];  // predicted results, oldest first
   char_item_type offered;
   result_type    oldest;
   int unsigned   queued_chars  = 0;
   int unsigned   mismatches    = 0;
   int unsigned   results_seen  = 0;
   int unsigned   hold_left     = 0;
   bit            hold_done     = 1'b0;
   bit            steady        = 1'b0; // suppress random idling on both sides
   int unsigned   quiet_cycles  = 0;

   // Configuration copy, reset values of the block
   bit           cfg_wildcard   = 1'b0;
   logic [127:0] cfg_name_chars = '0;
   logic [4:0]   cfg_name_len   = 5'd0;
   logic [4:0]   cfg_name_cap   = 5'd16;
   logic [7:0]   cfg_value_cap  = 8'd255;

   // Line state of the predictor
   phase_type     line_phase  = PH_SKIP;
   int            name_pos    = 0;
   int            value_cnt   = 0;
   bit            line_failed = 1'b0;
   char_kind_type out_kind;
   logic [7:0]    out_byte;
   logic [7:0]    out_index;

   // ------------------------------------------------------------------
   // Line parser prediction
   // ------------------------------------------------------------------
   function automatic bit is_blank(logic [7:0] c);
      return c == CH_TAB || c == CH_SPACE;
   endfunction

   function automatic bit is_alnum(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
   endfunction

   // Lengths above the name buffer size behave as the full buffer
   function automatic int clamp_name(logic [4:0] v);
      return (v > MAX_NAME) ? int'(MAX_NAME) : int'(v);
   endfunction

   function automatic void fail_line();
      line_failed = 1'b1;
      line_phase  = PH_DONE;
   endfunction

   function automatic void emit(char_kind_type kind, logic [7:0] c, int idx);
      out_kind  = kind;
      out_byte  = c;
      out_index = 8'(idx);
   endfunction

   function automatic void take_eq(logic [7:0] c);
      if (is_blank(c)) begin
         line_phase = PH_EQ;
      end else if (c == CH_EQUAL) begin
         line_phase = PH_POSTEQ;
      end else begin
         fail_line();
      end
   endfunction

   function automatic void take_value(logic [7:0] c);
      if (value_cnt >= int'(cfg_value_cap) || !is_alnum(c)) begin
         line_phase = PH_DONE;
      end else begin
         emit(KIND_VALUE, c, value_cnt);
         value_cnt++;
         line_phase = (value_cnt >= int'(cfg_value_cap)) ? PH_DONE : PH_UNQUOTED;
      end
   endfunction

   function automatic void take_name(logic [7:0] c);
      int limit;
      if (cfg_wildcard) begin
         limit = clamp_name(cfg_name_cap);
         if (name_pos >= limit || !is_alnum(c)) begin
            // an empty captured name fails; otherwise the name just ended
            if (name_pos == 0) fail_line();
            else take_eq(c);
         end else begin
            emit(KIND_NAME, c, name_pos);
            name_pos++;
            line_phase = (name_pos >= limit) ? PH_EQ : PH_NAME;
         end
      end else begin
         limit = clamp_name(cfg_name_len);
         if (name_pos >= limit) begin
            take_eq(c);
         end else if (c != cfg_name_chars[8*name_pos +: 8]) begin
            fail_line();
         end else begin
            name_pos++;
            line_phase = (name_pos >= limit) ? PH_EQ : PH_NAME;
         end
      end
   endfunction

   function automatic void take_char(logic [7:0] c);
      case (line_phase)
         PH_SKIP: begin
            if (!is_blank(c)) take_name(c);
         end
         PH_NAME: begin
            take_name(c);
         end
         PH_EQ: begin
            take_eq(c);
         end
         PH_POSTEQ: begin
            if (is_blank(c)) begin
            end else if (c == CH_QUOTE) begin
               line_phase = (cfg_value_cap == 8'd0) ? PH_DONE : PH_QUOTED;
            end else begin
               take_value(c);
            end
         end
         PH_QUOTED: begin
            if (c == CH_QUOTE || c == CH_LF || c == CH_CR) begin
               line_phase = PH_DONE;
            end else begin
               emit(KIND_VALUE, c, value_cnt);
               value_cnt++;
               if (value_cnt >= int'(cfg_value_cap)) line_phase = PH_DONE;
            end
         end
         PH_UNQUOTED: begin
            take_value(c);
         end
         default: begin
         end
      endcase
   endfunction

   // Advance the line state by one character and return the result it causes
   function automatic result_type predict_char(logic [7:0] c, logic eol);
      bit         ends;
      logic [7:0] len;
      result_type r;
      ends      = eol || c == CH_NUL;
      len       = 8'd0;
      out_kind  = KIND_NONE;
      out_byte  = 8'd0;
      out_index = 8'd0;
      // a NUL only ends the line, it is never parsed
      if (c != CH_NUL) take_char(c);
      if (ends) begin
         if (!line_failed &&
             (line_phase == PH_QUOTED || line_phase == PH_UNQUOTED || line_phase == PH_DONE))
            len = 8'(value_cnt);
         line_phase  = PH_SKIP;
         name_pos    = 0;
         value_cnt   = 0;
         line_failed = 1'b0;
      end
      r.char_kind    = out_kind;
      r.char_byte    = out_byte;
      r.char_index   = out_index;
      r.line_done    = ends;
      r.value_length = len;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Character source
   // ------------------------------------------------------------------
   function automatic logic [7:0] rand_alnum();
      int unsigned r;
      r = $urandom_range(0, 61);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("A" + r - 10);
      return 8'("a" + r - 36);
   endfunction

   task automatic push_char(logic [7:0] c, logic eol);
      pending_chars.push_back('{ch: c, eol: eol});
      queued_chars++;
   endtask

   task automatic push_text(string s, bit eol_last);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], eol_last && i == s.len() - 1);
   endtask

   // Build one line: mostly well-formed with random content, some noise and
   // some lines with a corrupted character
   task automatic push_random_line();
      logic [7:0] text[$];
      int         len;
      int         limit;
      int unsigned pick;
      if ($urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         if (cfg_wildcard) begin
            len = $urandom_range(0, clamp_name(cfg_name_cap) + 1);
            repeat (len) text.push_back(rand_alnum());
         end else begin
            len = clamp_name(cfg_name_len);
            for (int k = 0; k < len; k++) text.push_back(cfg_name_chars[8*k +: 8]);
         end
         repeat ($urandom_range(0, 2)) text.push_back(CH_SPACE);
         text.push_back(CH_EQUAL);
         repeat ($urandom_range(0, 2)) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         // short values, but reach past the capacity when it is small
         limit = (cfg_value_cap <= 8'd16) ? int'(cfg_value_cap) + 1 : 8;
         len   = $urandom_range(0, limit);
         pick  = $urandom_range(0, 2);
         if (pick == 0) begin
            text.push_back(CH_QUOTE);
            repeat (len) text.push_back(8'($urandom_range(8'h20, 8'h7E)));
            case ($urandom_range(0, 3))
               0: text.push_back(CH_QUOTE);
               1: text.push_back(CH_LF);
               2: text.push_back(CH_CR);
               default: begin
               end
            endcase
         end else begin
            repeat (len) text.push_back(rand_alnum());
         end
         if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(1, 255)));
         if ($urandom_range(0, 99) < 12)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      // end the line by its last character or by a trailing NUL
      if ($urandom_range(0, 99) < 10) begin
         foreach (text[k]) push_char(text[k], 1'b0);
         push_char(CH_NUL, 1'($urandom_range(0, 1)));
      end else begin
         foreach (text[k]) push_char(text[k], k == text.size() - 1);
      end
   endtask

   // ------------------------------------------------------------------
   // Configuration writes, only while the block is idle
   // ------------------------------------------------------------------
   task automatic write_csr(csr_index_type idx, logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WILDCARD_MODE:   cfg_wildcard          = data[0];
         CSR_NAME_CHARS_LOW:  cfg_name_chars[63:0]  = data;
         CSR_NAME_CHARS_HIGH: cfg_name_chars[127:64] = data;
         CSR_NAME_LENGTH:     cfg_name_len          = data[4:0];
         CSR_NAME_CAPACITY:   cfg_name_cap          = data[4:0];
         CSR_VALUE_CAPACITY:  cfg_value_cap         = data[7:0];
         default: begin
         end
      endcase
   endtask

   // Write every register; the unused upper data bits carry random junk
   task automatic configure(bit wild, logic [127:0] chars, logic [4:0] nlen,
                            logic [4:0] ncap, logic [7:0] vcap);
      write_csr(CSR_WILDCARD_MODE,   {{$urandom, $urandom}} & ~64'd1 | 64'(wild));
      write_csr(CSR_NAME_CHARS_LOW,  chars[63:0]);
      write_csr(CSR_NAME_CHARS_HIGH, chars[127:64]);
      write_csr(CSR_NAME_LENGTH,     {$urandom, $urandom} & ~64'h1F | 64'(nlen));
      write_csr(CSR_NAME_CAPACITY,   {$urandom, $urandom} & ~64'h1F | 64'(ncap));
      write_csr(CSR_VALUE_CAPACITY,  {$urandom, $urandom} & ~64'hFF | 64'(vcap));
   endtask

   // Wait until every character is taken and every result is back, then let
   // the two pipeline stages settle
   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Input driver: offer the next character, with random idle gaps unless steady, when the slot is free
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // predict at the transaction edge, in acceptance order
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_char(req_tdata, req_tlast));
         if (!req_tvalid || req_tready) begin
            if (pending_chars.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               offered = pending_chars.pop_front();
               req_tdata  <= offered.ch;
               req_tlast  <= offered.eol;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor and receiver back-pressure
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected result: char_byte %02h line_done %0d",
                      rsp_tdata[7:0], rsp_tlast);
               mismatches++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_tuser !== oldest.char_kind) begin
                  $error("char_kind: expected %0d, actual %0d", oldest.char_kind, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[7:0] !== oldest.char_byte) begin
                  $error("char_byte: expected %02h, actual %02h",
                         oldest.char_byte, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[15:8] !== oldest.char_index) begin
                  $error("char_index: expected %0d, actual %0d",
                         oldest.char_index, rsp_tdata[15:8]);
                  mismatches++;
               end
               if (rsp_tlast !== oldest.line_done) begin
                  $error("line_done: expected %0d, actual %0d", oldest.line_done, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tdata[23:16] !== oldest.value_length) begin
                  $error("value_length: expected %0d, actual %0d",
                         oldest.value_length, rsp_tdata[23:16]);
                  mismatches++;
               end
            end
         end
         // Hold off once for a long stretch so the block fills and stalls its
         // input while the driver keeps offering characters
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || $urandom_range(0, 99) >= IDLE_PERCENT;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: count cycles in which no transaction moves on any channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      logic [127:0] chars;
      logic [4:0]   nlen;
      logic [4:0]   ncap;
      logic [7:0]   vcap;
      bit           wild;
      int unsigned  phase_start;
      int           len;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: empty match name, so the line must open with '='
      push_text("=7", 1'b1);
      push_text("a=1", 1'b1);
      push_char(CH_NUL, 1'b0);          // a lone NUL ends the line without end_of_line
      wait_drained();

      // Match the single-character name "k"
      chars      = {$urandom, $urandom, $urandom, $urandom};
      chars[7:0] = "k";
      configure(1'b0, chars, 5'd1, 5'd16, 8'd255);
      push_text("\tk =\"a\n", 1'b1);    // quoted value closed by LF
      push_text("k=\"b", 1'b1);         // quote still open at the line end
      push_text("k= !", 1'b1);          // value starts with a non-alphanumeric
      push_text("k=x ", 1'b0);          // trailing characters are ignored
      push_char(8'hFF, 1'b1);
      push_text("k", 1'b0);             // line ends after the name, before any '='
      push_char(CH_NUL, 1'b1);
      wait_drained();

      // Random phases, each under its own register setting
      for (int ph = 0; ph < 7; ph++) begin
         vcap = 8'd255;
         ncap = 5'd16;
         case (ph)
            0: begin wild = 1'b0; nlen = 5'($urandom_range(1, 6));             end
            1: begin wild = 1'b1; nlen = 5'd0;  vcap = 8'd8;                    end
            2: begin wild = 1'b1; nlen = 5'd0;  ncap = 5'd0;  vcap = 8'd0;      end
            3: begin wild = 1'b1; nlen = 5'd31; ncap = 5'd31; vcap = 8'd1;      end
            4: begin wild = 1'b0; nlen = 5'd16; vcap = 8'd3;                    end
            5: begin wild = 1'b0; nlen = 5'd31; vcap = 8'd0;                    end
            default: begin wild = 1'b1; nlen = 5'd5; ncap = 5'd2;               end
         endcase
         // match names are printable; wildcard phases write random name data
         chars = {$urandom, $urandom, $urandom, $urandom};
         if (!wild)
            for (int k = 0; k < 16; k++) chars[8*k +: 8] = 8'($urandom_range(8'h21, 8'h7E));
         configure(wild, chars, nlen, ncap, vcap);
         steady = (ph == 1);

         phase_start = queued_chars;
         if (ph == 0) begin
            // one quoted value past the largest capacity
            len = clamp_name(cfg_name_len);
            for (int k = 0; k < len; k++) push_char(cfg_name_chars[8*k +: 8], 1'b0);
            push_char(CH_EQUAL, 1'b0);
            push_char(CH_QUOTE, 1'b0);
            for (int k = 0; k < 258; k++) push_char(8'($urandom_range(8'h23, 8'h7E)), k == 257);
            phase_start = queued_chars;
         end
         while (queued_chars - phase_start < PHASE_CHARS) push_random_line();
         wait_drained();
         steady = 1'b0;
      end

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
